// ===== design/display_idle_dim_controller_defines.svh =====
`ifndef DISPLAY_IDLE_DIM_CONTROLLER_DEFINES_SVH
`define DISPLAY_IDLE_DIM_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DIDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DIDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/didc_pkg.sv =====
package didc_pkg;

    localparam int CNT_W        = 32;
    localparam int TIMEOUT_W    = 16;
    localparam int BRIGHT_W     = 8;
    localparam int KIND_W       = 3;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    localparam int TPS_DEFAULT   = 1000;
    localparam int DEFAULT_DIM_S = 30;

    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLEEP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAKEUP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IMAGE    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_DIM     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IMAGE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIM_OFF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_BRIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_BRIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAVER_MODE  = 3'd5;

    typedef struct packed {
        logic                enabled;
        logic [MODE_W-1:0]   saver_mode;
        logic [BRIGHT_W-1:0] dim_brightness;
        logic [BRIGHT_W-1:0] active_brightness;
    } cfg_t;

    typedef struct packed {
        logic clr_all;
        logic clr_idle;
    } clr_t;

    typedef struct packed {
        logic                showing_image;
        logic                is_dimmed;
        logic                display_on;
        logic [BRIGHT_W-1:0] brightness;
    } result_t;

endpackage

// ===== design/display_idle_dim_controller.sv =====
// Idle-timeout backlight controller. Each event request (tick, activity, force sleep,
// wakeup, image changed) yields one status result; a new request is taken every cycle
// while m_tready does not back-pressure. The request lands in the input register, and
// the state update loads its result into the result register; only m_tready
// back-pressure can stall this path. The single state update per
// cycle sets the rate. Timeouts are converted to tick counts by one multiplier when
// dim_timeout_s or off_timeout_s is written, so the event path holds only a 32-bit
// increment and compare. Configuration writes are always taken; write only while no
// request is in flight.
module display_idle_dim_controller #(
    parameter int TICKS_PER_SECOND = didc_pkg::TPS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [didc_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] image_present
    input  logic [didc_pkg::KIND_W-1:0]      s_tuser,   // [2:0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] brightness, [8] display_on, [9] is_dimmed, [10] showing_image
    output logic [didc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [didc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [didc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import didc_pkg::*;

    localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int THR_W = TIMEOUT_W + TPS_W;

    cfg_t              cfg;
    clr_t              clr;
    logic [THR_W-1:0]  dim_thr, off_thr;
    result_t           result;

    logic              in_valid_reg, in_valid_next;
    logic [KIND_W-1:0] in_kind_reg;
    logic              in_img_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              advance, fire, take;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    didc_cfg #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .THR_W            (THR_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clr       (clr),
        .dim_thr   (dim_thr),
        .off_thr   (off_thr)
    );

    didc_core #(
        .THR_W (THR_W)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (fire),
        .kind          (in_kind_reg),
        .image_present (in_img_reg),
        .cfg           (cfg),
        .clr           (clr),
        .dim_thr       (dim_thr),
        .off_thr       (off_thr),
        .result        (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_kind_reg <= s_tuser;
            in_img_reg  <= s_tdata[0];
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.showing_image, out_reg.is_dimmed,
                                  out_reg.display_on, out_reg.brightness});

endmodule

// ===== design/didc_cfg.sv =====
module didc_cfg #(
    parameter int TICKS_PER_SECOND = didc_pkg::TPS_DEFAULT,
    parameter int THR_W            = 17
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [didc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [didc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output didc_pkg::cfg_t                   cfg,
    output didc_pkg::clr_t                   clr,
    output logic [THR_W-1:0]                 dim_thr,
    output logic [THR_W-1:0]                 off_thr
);
    import didc_pkg::*;

    localparam logic [THR_W-1:0] TPS_C     = THR_W'(TICKS_PER_SECOND);
    localparam logic [THR_W-1:0] DIM_THR_RST = THR_W'(DEFAULT_DIM_S * TICKS_PER_SECOND);

    cfg_t                  cfg_reg, cfg_next;
    logic [THR_W-1:0]      dim_thr_reg, dim_thr_next;
    logic [THR_W-1:0]      off_thr_reg, off_thr_next;
    logic [TIMEOUT_W-1:0]  mul_a;
    logic [THR_W-1:0]      product;
    logic                  wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // one shared multiplier turns seconds into ticks at write time
    assign mul_a   = (cfg_index == REG_DIM_TIMEOUT && cfg_data == '0)
                     ? TIMEOUT_W'(DEFAULT_DIM_S) : cfg_data[TIMEOUT_W-1:0];
    assign product = THR_W'(mul_a) * TPS_C;

    always_comb begin
        cfg_next     = cfg_reg;
        dim_thr_next = dim_thr_reg;
        off_thr_next = off_thr_reg;
        clr          = '0;
        if (wr) begin
            case (cfg_index)
                REG_ENABLED: begin
                    cfg_next.enabled = cfg_data[0];
                    clr.clr_all      = 1'b1;
                end
                REG_DIM_TIMEOUT: begin
                    dim_thr_next = product;
                    clr.clr_idle = 1'b1;
                end
                REG_OFF_TIMEOUT: off_thr_next = product;
                REG_DIM_BRIGHT:  cfg_next.dim_brightness = cfg_data[BRIGHT_W-1:0];
                REG_ACT_BRIGHT:  cfg_next.active_brightness = cfg_data[BRIGHT_W-1:0];
                REG_SAVER_MODE:  cfg_next.saver_mode = cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled           <= 1'b1;
            cfg_reg.saver_mode        <= MODE_DIM;
            cfg_reg.dim_brightness    <= BRIGHT_W'(64);
            cfg_reg.active_brightness <= BRIGHT_W'(255);
            dim_thr_reg               <= DIM_THR_RST;
            off_thr_reg               <= '0;
        end else begin
            cfg_reg     <= cfg_next;
            dim_thr_reg <= dim_thr_next;
            off_thr_reg <= off_thr_next;
        end
    end

    assign cfg     = cfg_reg;
    assign dim_thr = dim_thr_reg;
    assign off_thr = off_thr_reg;

endmodule

// ===== design/didc_core.sv =====
module didc_core #(
    parameter int THR_W = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  logic [didc_pkg::KIND_W-1:0]   kind,
    input  logic                          image_present,
    input  didc_pkg::cfg_t                cfg,
    input  didc_pkg::clr_t                clr,
    input  logic [THR_W-1:0]              dim_thr,
    input  logic [THR_W-1:0]              off_thr,
    output didc_pkg::result_t             result
);
    import didc_pkg::*;

    localparam int CMP_W = (THR_W > CNT_W) ? THR_W : CNT_W;

    logic [CNT_W-1:0] idle_reg, idle_next;
    logic [CNT_W-1:0] dimmed_reg, dimmed_next;
    logic             dim_reg, dim_next;
    logic             off_reg, off_next;
    logic             img_reg, img_next;
    logic [CNT_W-1:0] idle_inc, dimmed_inc;
    logic             idle_hit, dimmed_hit;

    assign idle_inc   = (idle_reg == '1) ? idle_reg : idle_reg + CNT_W'(1);
    assign dimmed_inc = (dimmed_reg == '1) ? dimmed_reg : dimmed_reg + CNT_W'(1);
    assign idle_hit   = CMP_W'(idle_inc) >= CMP_W'(dim_thr);
    assign dimmed_hit = CMP_W'(dimmed_inc) >= CMP_W'(off_thr);

    always_comb begin
        idle_next   = idle_reg;
        dimmed_next = dimmed_reg;
        dim_next    = dim_reg;
        off_next    = off_reg;
        img_next    = img_reg;
        if (clr.clr_all) begin
            idle_next = '0;
            dim_next  = 1'b0;
            off_next  = 1'b0;
            img_next  = 1'b0;
        end else if (clr.clr_idle) begin
            idle_next = '0;
        end else if (item_valid) begin
            case (kind)
                KIND_TICK: begin
                    idle_next = idle_inc;
                    if (dim_reg) begin
                        dimmed_next = dimmed_inc;
                    end
                    if (cfg.enabled) begin
                        if (!dim_reg) begin
                            if (idle_hit) begin
                                dim_next    = 1'b1;
                                off_next    = 1'b0;
                                dimmed_next = '0;
                                img_next    = (cfg.saver_mode == MODE_IMAGE) && image_present;
                            end
                        end else if (cfg.saver_mode == MODE_DIM_OFF && !off_reg &&
                                     off_thr != '0 && dimmed_hit) begin
                            off_next = 1'b1;
                            img_next = 1'b0;
                        end
                    end
                end
                KIND_ACTIVITY: begin
                    idle_next = '0;
                    if (cfg.enabled && dim_reg) begin
                        dim_next = 1'b0;
                        off_next = 1'b0;
                        img_next = 1'b0;
                    end
                end
                KIND_SLEEP: begin
                    if (cfg.enabled) begin
                        dim_next    = 1'b1;
                        off_next    = 1'b0;
                        dimmed_next = '0;
                        img_next    = (cfg.saver_mode == MODE_IMAGE) && image_present;
                    end
                end
                KIND_WAKEUP: begin
                    idle_next = '0;
                    dim_next  = 1'b0;
                    off_next  = 1'b0;
                    img_next  = 1'b0;
                end
                KIND_IMAGE: begin
                    if (img_reg && !image_present) begin
                        img_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg   <= '0;
            dimmed_reg <= '0;
            dim_reg    <= 1'b0;
            off_reg    <= 1'b0;
            img_reg    <= 1'b0;
        end else begin
            idle_reg   <= idle_next;
            dimmed_reg <= dimmed_next;
            dim_reg    <= dim_next;
            off_reg    <= off_next;
            img_reg    <= img_next;
        end
    end

    always_comb begin
        if (off_next) begin
            result.brightness = '0;
        end else if (dim_next && !img_next) begin
            result.brightness = cfg.dim_brightness;
        end else begin
            result.brightness = cfg.active_brightness;
        end
        result.display_on    = !off_next;
        result.is_dimmed     = dim_next;
        result.showing_image = img_next;
    end

endmodule

// ===== design/didc_chk.sv =====
`include "display_idle_dim_controller_defines.svh"

module didc_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [didc_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [didc_pkg::KIND_W-1:0]      s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [didc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [didc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [didc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // stalled result holds
    `DIDC_ASSERT_NXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // panel off means dimmed at zero brightness with no image
    `DIDC_ASSERT_IMP(a_off_dark, aclk, aresetn, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'd0 && m_tdata[9] && !m_tdata[10], "off state with light or image")

    // image is shown only while dimmed and panel on
    `DIDC_ASSERT_IMP(a_img_dim, aclk, aresetn, m_tvalid && m_tdata[10], m_tdata[9] && m_tdata[8], "image outside dimmed state")

    // active state keeps the panel on
    `DIDC_ASSERT_IMP(a_active_on, aclk, aresetn, m_tvalid && !m_tdata[9], m_tdata[8], "panel off while active")

endmodule

bind display_idle_dim_controller didc_chk u_didc_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
